>>> src/lfpd_pkg.sv
package lfpd_pkg;

	// Scan line geometry
	localparam int LINE_WIDTH = 320;
	localparam int COL_W      = $clog2(LINE_WIDTH);
	localparam int HALF_WIDTH = LINE_WIDTH / 2;

	// Field widths
	localparam int PIX_W  = 8;
	localparam int ERR_W  = 18;
	localparam int CNT_W  = 11;
	localparam int SPD_W  = 9;
	localparam int BASE_W = 8;
	localparam int DIV_W  = 16;
	localparam int GAIN_W = 16;
	localparam int LOST_W = 4;
	localparam int IDX_W  = 2;
	localparam int DATA_W = 16;

	// Divider step count, one quotient bit a cycle
	localparam int DIV_STEPS = ERR_W;
	localparam int DCNT_W    = $clog2(DIV_STEPS);

	// Register reset values
	localparam logic [BASE_W-1:0] BASE_RST = BASE_W'(50);
	localparam logic [DIV_W-1:0]  DIV_RST  = DIV_W'(300);
	localparam logic [GAIN_W-1:0] GAIN_RST = GAIN_W'(128);
	localparam logic [LOST_W-1:0] LOST_RST = LOST_W'(2);

	// Register indexes
	typedef enum logic [IDX_W-1:0] {
		CFG_BASE_SPEED = 2'd0,
		CFG_PROP_DIV   = 2'd1,
		CFG_DERIV_GAIN = 2'd2,
		CFG_LOST_GAIN  = 2'd3
	} lfpd_cfg_idx_e;

	// Controller states
	typedef enum logic [2:0] {
		ST_ACCUM,
		ST_DIV,
		ST_MULT,
		ST_SUM,
		ST_FIN
	} lfpd_state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic pix_take;
		logic line_end;
		logic div_step;
		logic mult_en;
		logic sum_en;
		logic out_load;
	} lfpd_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic div_last;
	} lfpd_stat_t;

endpackage

>>> src/lfpd_pix_if.sv
interface lfpd_pix_if;
	logic                       valid;
	logic                       ready;
	logic                       req_type;
	logic [lfpd_pkg::PIX_W-1:0] pixel;
	logic                       last_pixel;

	modport source (output valid, output req_type, output pixel, output last_pixel,
		input ready);
	modport sink (input valid, input req_type, input pixel, input last_pixel,
		output ready);
endinterface

>>> src/lfpd_res_if.sv
interface lfpd_res_if;
	logic                              valid;
	logic                              ready;
	logic signed [lfpd_pkg::SPD_W-1:0] left_speed;
	logic signed [lfpd_pkg::SPD_W-1:0] right_speed;
	logic                              line_seen;
	logic signed [lfpd_pkg::ERR_W-1:0] line_error;
	logic [lfpd_pkg::CNT_W-1:0]        bright_count;

	modport source (output valid, output left_speed, output right_speed,
		output line_seen, output line_error, output bright_count, input ready);
	modport sink (input valid, input left_speed, input right_speed,
		input line_seen, input line_error, input bright_count, output ready);
endinterface

>>> src/lfpd_cfg_if.sv
interface lfpd_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [lfpd_pkg::IDX_W-1:0]  index;
	logic [lfpd_pkg::DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> src/lfpd_ctrl.sv
module lfpd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pix_valid,
	input  logic                 pix_last,
	input  logic                 pix_req,
	input  logic                 res_ready,
	input  lfpd_pkg::lfpd_stat_t stat,
	output lfpd_pkg::lfpd_cmd_t  cmd,
	output logic                 pix_ready,
	output logic                 res_valid
);
	import lfpd_pkg::*;

	lfpd_state_t state_q;
	lfpd_state_t state_d;
	logic        res_valid_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCUM;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		pix_ready = 1'b0;
		case (state_q)
			ST_ACCUM: begin
				pix_ready    = 1'b1;
				cmd.pix_take = pix_valid;
				if (pix_valid && pix_last && pix_req) begin
					cmd.line_end = 1'b1;
					state_d      = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = ST_MULT;
				end
			end
			ST_MULT: begin
				cmd.mult_en = 1'b1;
				state_d     = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum_en = 1'b1;
				state_d    = ST_FIN;
			end
			ST_FIN: begin
				// wait for the result register to free up
				if (!res_valid_q || res_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_ACCUM;
				end
			end
			default: begin
				state_d = ST_ACCUM;
			end
		endcase
	end

	// Result beat pending flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res_valid = res_valid_q;

endmodule

>>> src/lfpd_datapath.sv
module lfpd_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  lfpd_pkg::lfpd_cmd_t                cmd,
	output lfpd_pkg::lfpd_stat_t               stat,
	input  logic                               req_type,
	input  logic [lfpd_pkg::PIX_W-1:0]         pixel,
	input  logic                               last_pixel,
	input  logic                               cfg_we,
	input  logic [lfpd_pkg::IDX_W-1:0]         cfg_index,
	input  logic [lfpd_pkg::DATA_W-1:0]        cfg_data,
	output logic signed [lfpd_pkg::SPD_W-1:0]  left_speed,
	output logic signed [lfpd_pkg::SPD_W-1:0]  right_speed,
	output logic                               line_seen,
	output logic signed [lfpd_pkg::ERR_W-1:0]  line_error,
	output logic [lfpd_pkg::CNT_W-1:0]         bright_count
);
	import lfpd_pkg::*;

	localparam int PROD_W = ERR_W + 1 + GAIN_W + 1;
	localparam int S_W    = PROD_W + 1;
	localparam int L_W    = S_W + 1;
	localparam int LOSTP_W = LOST_W + 1 + ERR_W;
	localparam int LOSTS_W = LOSTP_W + 1;
	localparam logic signed [ERR_W-1:0] ERR_MAX = {1'b0, {(ERR_W-1){1'b1}}};
	localparam logic signed [ERR_W-1:0] ERR_MIN = {1'b1, {(ERR_W-1){1'b0}}};

	// Saturate a Q8 speed sum to +-255 after truncation toward zero
	function automatic logic signed [SPD_W-1:0] sat_q8(input logic signed [L_W-1:0] v);
		logic signed [SPD_W-1:0] t;
		if (v >= L_W'(65536)) begin
			sat_q8 = SPD_W'(255);
		end else if (v <= -L_W'(65536)) begin
			sat_q8 = -SPD_W'(255);
		end else begin
			t = v[SPD_W+7:8];
			if (v[L_W-1] && (v[7:0] != 8'd0)) begin
				t = t + SPD_W'(1);
			end
			sat_q8 = t;
		end
	endfunction

	// Saturate a whole speed to +-255
	function automatic logic signed [SPD_W-1:0] sat_lin(input logic signed [LOSTS_W-1:0] v);
		if (v > LOSTS_W'(255)) begin
			sat_lin = SPD_W'(255);
		end else if (v < -LOSTS_W'(255)) begin
			sat_lin = -SPD_W'(255);
		end else begin
			sat_lin = v[SPD_W-1:0];
		end
	endfunction

	// Configuration registers
	logic [BASE_W-1:0] base_q;
	logic [DIV_W-1:0]  pdiv_q;
	logic [GAIN_W-1:0] gain_q;
	logic [LOST_W-1:0] lost_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RST;
			pdiv_q <= DIV_RST;
			gain_q <= GAIN_RST;
			lost_q <= LOST_RST;
		end else if (cfg_we) begin
			case (lfpd_cfg_idx_e'(cfg_index))
				CFG_BASE_SPEED: base_q <= cfg_data[BASE_W-1:0];
				CFG_PROP_DIV:   pdiv_q <= cfg_data[DIV_W-1:0];
				CFG_DERIV_GAIN: gain_q <= cfg_data[GAIN_W-1:0];
				CFG_LOST_GAIN:  lost_q <= cfg_data[LOST_W-1:0];
				default: ;
			endcase
		end
	end

	// Line state
	logic [COL_W-1:0]        col_q;
	logic [PIX_W-1:0]        bmax_q;
	logic [PIX_W-1:0]        dmin_q;
	logic signed [ERR_W-1:0] eacc_q;
	logic [CNT_W-1:0]        cacc_q;
	logic signed [ERR_W-1:0] prior_err_q;
	logic signed [ERR_W-1:0] prior_p_q;

	logic [PIX_W:0]          thr_sum;
	logic                    marked;
	logic signed [COL_W:0]   offset;
	logic signed [ERR_W:0]   esum;
	logic signed [ERR_W-1:0] esat;
	logic signed [ERR_W-1:0] eacc_d;
	logic [CNT_W-1:0]        cacc_d;
	logic [ERR_W-1:0]        eabs;

	// Threshold test and accumulate with saturation
	always_comb begin
		thr_sum = {1'b0, bmax_q} + {1'b0, dmin_q};
		marked  = req_type && (pixel >= thr_sum[PIX_W:1]);
		offset  = signed'({1'b0, col_q}) - (COL_W+1)'(HALF_WIDTH);
		esum    = (ERR_W+1)'(eacc_q) + (ERR_W+1)'(offset);
		if (esum[ERR_W] != esum[ERR_W-1]) begin
			esat = esum[ERR_W] ? ERR_MIN : ERR_MAX;
		end else begin
			esat = esum[ERR_W-1:0];
		end
		eacc_d = marked ? esat : eacc_q;
		cacc_d = (marked && (cacc_q != {CNT_W{1'b1}})) ? cacc_q + CNT_W'(1) : cacc_q;
		eabs   = eacc_d[ERR_W-1] ? (~eacc_d + ERR_W'(1)) : eacc_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			bmax_q <= '0;
			dmin_q <= '1;
			eacc_q <= '0;
			cacc_q <= '0;
		end else if (cmd.pix_take) begin
			if (!req_type) begin
				if (pixel > bmax_q) bmax_q <= pixel;
				if (pixel < dmin_q) dmin_q <= pixel;
			end
			if (last_pixel) begin
				col_q  <= '0;
				eacc_q <= '0;
				cacc_q <= '0;
			end else begin
				if (col_q < COL_W'(LINE_WIDTH - 1)) col_q <= col_q + COL_W'(1);
				eacc_q <= eacc_d;
				cacc_q <= cacc_d;
			end
		end
	end

	// Restoring divider on the error magnitude
	logic signed [ERR_W-1:0] err_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [DIV_W-1:0]        rem_q;
	logic [ERR_W-1:0]        dvd_q;
	logic                    neg_q;
	logic [DCNT_W-1:0]       dcnt_q;
	logic [DIV_W-1:0]        dsor;
	logic [DIV_W:0]          trial;
	logic                    qbit;

	always_comb begin
		dsor  = (pdiv_q == '0) ? DIV_W'(1) : pdiv_q;
		trial = {rem_q, dvd_q[ERR_W-1]};
		qbit  = trial >= {1'b0, dsor};
	end

	assign stat.div_last = dcnt_q == DCNT_W'(DIV_STEPS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (cmd.line_end) begin
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			dcnt_q <= dcnt_q + DCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.line_end) begin
			err_q <= eacc_d;
			cnt_q <= cacc_d;
			rem_q <= '0;
			dvd_q <= eabs;
			neg_q <= eacc_d[ERR_W-1];
		end else if (cmd.div_step) begin
			rem_q <= qbit ? DIV_W'(trial - {1'b0, dsor}) : trial[DIV_W-1:0];
			dvd_q <= {dvd_q[ERR_W-2:0], qbit};
		end
	end

	// Proportional term, derivative and lost products
	logic signed [ERR_W-1:0]   p_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [LOSTP_W-1:0] lprod_q;
	logic signed [ERR_W:0]     diff;

	assign diff = (ERR_W+1)'(err_q) - (ERR_W+1)'(prior_err_q);

	always_ff @(posedge clk) begin
		if (cmd.mult_en) begin
			p_q     <= neg_q ? -signed'(dvd_q) : signed'(dvd_q);
			prod_q  <= PROD_W'(diff) * PROD_W'(signed'({1'b0, gain_q}));
			lprod_q <= LOSTP_W'(signed'({1'b0, lost_q})) * LOSTP_W'(prior_p_q);
		end
	end

	// Steering signal in Q8
	logic signed [S_W-1:0] s_q;

	always_ff @(posedge clk) begin
		if (cmd.sum_en) begin
			s_q <= S_W'(signed'({p_q, 8'd0})) + S_W'(prod_q);
		end
	end

	// Wheel speeds and result register
	logic signed [L_W-1:0]     bq8;
	logic signed [LOSTS_W-1:0] bl;
	logic                      seen;
	logic signed [SPD_W-1:0]   left_d;
	logic signed [SPD_W-1:0]   right_d;

	always_comb begin
		bq8  = signed'(L_W'({base_q, 8'd0}));
		bl   = signed'(LOSTS_W'(base_q));
		seen = cnt_q != '0;
		if (seen) begin
			left_d  = sat_q8(bq8 + L_W'(s_q));
			right_d = sat_q8(bq8 - L_W'(s_q));
		end else begin
			left_d  = sat_lin(bl + LOSTS_W'(lprod_q));
			right_d = sat_lin(bl - LOSTS_W'(lprod_q));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			left_speed   <= left_d;
			right_speed  <= right_d;
			line_seen    <= seen;
			line_error   <= err_q;
			bright_count <= cnt_q;
		end
	end

	// Keep history only when the line was seen
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prior_err_q <= '0;
			prior_p_q   <= '0;
		end else if (cmd.out_load && seen) begin
			prior_err_q <= err_q;
			prior_p_q   <= p_q;
		end
	end

endmodule

>>> src/line_follow_pd_steering.sv
// PD steering for a line follower, fed one camera scan line as pixel beats.
// Channels: pix takes one pixel beat a cycle (req_type, pixel, last_pixel);
// a calibration line (req_type 0) tracks the brightest and darkest pixel, a
// tracking line (req_type 1) accumulates the offsets of pixels at or above
// the midpoint threshold. res carries one beat per tracking line: both wheel
// speeds, line_seen, line_error and bright_count. cfg writes base_speed,
// prop_divisor, deriv_gain_q8 and lost_gain; it is always ready.
// Throughput: one pixel per cycle within a line. After the last pixel of a
// tracking line pix drops ready while the bit-serial divider forms the
// proportional term (ST_DIV), then through ST_MULT for the multipliers,
// ST_SUM for the Q8 sum and ST_FIN, where the saturated speeds are loaded
// into the result register. Calibration lines give no result and no gap.
// Stall: one result register holds the beat until res.ready; a following
// tracking line is accepted meanwhile and waits at its final step only.
// Reset: registers return to their defaults, calibration to bright 0 and
// dark 255 (threshold 127), history to zero, both channels idle.
module line_follow_pd_steering (
	input logic        clk,
	input logic        arst_n,
	lfpd_pix_if.sink   pix,
	lfpd_res_if.source res,
	lfpd_cfg_if.sink   cfg
);
	import lfpd_pkg::*;

	lfpd_cmd_t  cmd;
	lfpd_stat_t stat;

	assign cfg.ready = 1'b1;

	lfpd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix.valid),
		.pix_last  (pix.last_pixel),
		.pix_req   (pix.req_type),
		.res_ready (res.ready),
		.stat      (stat),
		.cmd       (cmd),
		.pix_ready (pix.ready),
		.res_valid (res.valid)
	);

	lfpd_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.req_type     (pix.req_type),
		.pixel        (pix.pixel),
		.last_pixel   (pix.last_pixel),
		.cfg_we       (cfg.valid),
		.cfg_index    (cfg.index),
		.cfg_data     (cfg.data),
		.left_speed   (res.left_speed),
		.right_speed  (res.right_speed),
		.line_seen    (res.line_seen),
		.line_error   (res.line_error),
		.bright_count (res.bright_count)
	);

	// A tracking line end starts the divider, so pix must drop ready
	a_busy_after_line: assert property (@(posedge clk) disable iff (!arst_n)
		pix.valid && pix.ready && pix.last_pixel && pix.req_type |=> !pix.ready)
		else $error("pix ready after tracking line end");

	// line_seen agrees with the pixel count
	a_seen_count: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.line_seen == (res.bright_count != '0)))
		else $error("line_seen disagrees with bright_count");

	// A lost line carries no error
	a_lost_error: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.line_seen |-> res.line_error == '0)
		else $error("lost line with non-zero error");

	// Saturation never yields -256
	a_speed_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.left_speed != -SPD_W'(256)) && (res.right_speed != -SPD_W'(256)))
		else $error("speed outside saturation range");

endmodule

>>> sim/line_follow_pd_steering_tb.sv
`timescale 1ns / 1ps

module line_follow_pd_steering_tb;
	import lfpd_pkg::*;

	localparam int SETTLE_CYCLES = 30;
	localparam int HOLD_CYCLES   = 400;
	localparam int PHASE_BEATS   = 150;
	localparam int RANDOM_BEATS  = 900;
	localparam int ERR_HI        = 2 ** (ERR_W - 1) - 1;
	localparam int ERR_LO        = -(2 ** (ERR_W - 1));
	localparam int CNT_HI        = 2 ** CNT_W - 1;
	localparam int SPD_LIM       = 255;
	localparam int REPORT_LIMIT  = 10;

	typedef struct {
		logic signed [SPD_W-1:0] left;
		logic signed [SPD_W-1:0] right;
		logic                    seen;
		logic signed [ERR_W-1:0] err;
		logic [CNT_W-1:0]        count;
	} steer_res_t;

	// Steering predictor and the store of expected steering beats
	class steer_scoreboard;
		int unsigned base_speed, prop_div, deriv_gain, lost_gain;
		int unsigned col, bright_hi, dark_lo, hit_count;
		int err_sum, prev_err, prev_prop;
		steer_res_t expected_steer[$];
		int mismatches, results_checked, lost_lines;

		function new();
			base_speed = BASE_RST;
			prop_div   = DIV_RST;
			deriv_gain = GAIN_RST;
			lost_gain  = LOST_RST;
			bright_hi  = 0;
			dark_lo    = 255;
			prev_err   = 0;
			prev_prop  = 0;
			col        = 0;
			err_sum    = 0;
			hit_count  = 0;
		endfunction

		function void set_reg(lfpd_cfg_idx_e idx, int unsigned val);
			case (idx)
				CFG_BASE_SPEED: base_speed = val & 'hFF;
				CFG_PROP_DIV:   prop_div = val & 'hFFFF;
				CFG_DERIV_GAIN: deriv_gain = val & 'hFFFF;
				CFG_LOST_GAIN:  lost_gain = val & 'hF;
				default: ;
			endcase
		endfunction

		function int threshold();
			return (bright_hi + dark_lo) / 2;
		endfunction

		function int pending();
			return expected_steer.size();
		endfunction

		// Advance the line state by one accepted pixel beat
		function void note_pixel(bit rt, bit [PIX_W-1:0] pv, bit last);
			longint acc, p, s, b, l, r, dv;
			steer_res_t e;
			if (!rt) begin
				if (pv > bright_hi) bright_hi = int'(pv);
				if (pv < dark_lo) dark_lo = int'(pv);
			end else if (pv >= threshold()) begin
				acc = longint'(err_sum) + longint'(col) - HALF_WIDTH;
				if (acc > ERR_HI) acc = ERR_HI;
				if (acc < ERR_LO) acc = ERR_LO;
				err_sum = int'(acc);
				if (hit_count < CNT_HI) hit_count++;
			end
			if (!last) begin
				if (col < LINE_WIDTH - 1) col++;
				return;
			end
			if (rt) begin
				if (hit_count != 0) begin
					dv = (prop_div == 0) ? 1 : longint'(prop_div);
					p = longint'(err_sum) / dv;
					s = p * 256 + (longint'(err_sum) - longint'(prev_err)) * longint'(deriv_gain);
					b = longint'(base_speed) * 256;
					l = (b + s) / 256;
					r = (b - s) / 256;
					prev_err = err_sum;
					prev_prop = int'(p);
				end else begin
					s = longint'(lost_gain) * longint'(prev_prop);
					l = longint'(base_speed) + s;
					r = longint'(base_speed) - s;
				end
				if (l > SPD_LIM) l = SPD_LIM;
				if (l < -SPD_LIM) l = -SPD_LIM;
				if (r > SPD_LIM) r = SPD_LIM;
				if (r < -SPD_LIM) r = -SPD_LIM;
				e.left  = l[SPD_W-1:0];
				e.right = r[SPD_W-1:0];
				e.seen  = (hit_count != 0);
				e.err   = err_sum[ERR_W-1:0];
				e.count = hit_count[CNT_W-1:0];
				expected_steer.push_back(e);
			end
			// clear the line accumulators at every line end
			col = 0;
			err_sum = 0;
			hit_count = 0;
		endfunction

		function void report(string msg);
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("[%0t] mismatch: %s", $realtime, msg);
		endfunction

		// Compare one steering beat with the oldest expectation
		function void check_result(steer_res_t got);
			steer_res_t want;
			if (expected_steer.size() == 0) begin
				report($sformatf("unexpected beat left=%0d right=%0d seen=%0b err=%0d cnt=%0d",
					got.left, got.right, got.seen, got.err, got.count));
				return;
			end
			want = expected_steer.pop_front();
			results_checked++;
			if (!want.seen) lost_lines++;
			if (got.left !== want.left || got.right !== want.right || got.seen !== want.seen ||
					got.err !== want.err || got.count !== want.count)
				report($sformatf({"exp left=%0d right=%0d seen=%0b err=%0d cnt=%0d, ",
					"got left=%0d right=%0d seen=%0b err=%0d cnt=%0d"},
					want.left, want.right, want.seen, want.err, want.count,
					got.left, got.right, got.seen, got.err, got.count));
		endfunction
	endclass

	logic clk;
	logic arst_n;

	lfpd_pix_if pix_ch ();
	lfpd_res_if res_ch ();
	lfpd_cfg_if cfg_ch ();

	line_follow_pd_steering dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	steer_scoreboard sb = new();

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_req = 0;
	int total_beats = 0;
	int total_lines = 0;
	int settings_used = 1;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// Result sink: check beats, randomise ready, honour long hold-offs
	initial begin
		int hold_left;
		steer_res_t got;
		hold_left = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
				got.left  = res_ch.left_speed;
				got.right = res_ch.right_speed;
				got.seen  = res_ch.line_seen;
				got.err   = res_ch.line_error;
				got.count = res_ch.bright_count;
				sb.check_result(got);
			end
			if (hold_req) begin
				hold_req = 0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// Offer one pixel beat, with random gaps, and note it once taken
	task automatic send_pixel(input bit rt, input bit [PIX_W-1:0] pv, input bit last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			pix_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pix_ch.valid      <= 1'b1;
		pix_ch.req_type   <= rt;
		pix_ch.pixel      <= pv;
		pix_ch.last_pixel <= last;
		do @(posedge clk); while (pix_ch.ready !== 1'b1);
		sb.note_pixel(rt, pv, last);
		total_beats++;
		if (last) total_lines++;
	endtask

	// Write all four registers back to back
	task automatic write_regs(input int unsigned base, input int unsigned dv,
			input int unsigned gain, input int unsigned lost);
		lfpd_cfg_idx_e idx;
		int unsigned vals[4];
		vals = '{base, dv, gain, lost};
		for (int i = 0; i < 4; i++) begin
			idx = lfpd_cfg_idx_e'(i);
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= idx;
			cfg_ch.data  <= DATA_W'(vals[i]);
			do @(posedge clk); while (cfg_ch.ready !== 1'b1);
			sb.set_reg(idx, vals[i]);
		end
		cfg_ch.valid <= 1'b0;
		settings_used++;
	endtask

	// Drop valid, wait for every expected beat, then let the pipeline settle
	task automatic wait_idle();
		pix_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One scan line: short calibration bursts, or tracking with a bright stripe
	task automatic send_line(input int len, input bit calib);
		int thr, s0, s1;
		bit rt, lost, last;
		bit [PIX_W-1:0] pv;
		lost = ($urandom_range(0, 99) < 8);
		s0 = $urandom_range(0, len - 1);
		s1 = s0 + $urandom_range(0, len / 3);
		for (int i = 0; i < len; i++) begin
			last = (i == len - 1);
			thr = sb.threshold();
			if (calib) begin
				rt = 1'b0;
				pv = PIX_W'($urandom_range(0, 255));
			end else begin
				rt = ($urandom_range(0, 99) >= (last ? 5 : 3));
				if ($urandom_range(0, 99) < 10)
					pv = PIX_W'($urandom_range(0, 255));
				else if (!lost && i >= s0 && i <= s1)
					pv = ($urandom_range(0, 99) < 20) ? PIX_W'(thr) :
						PIX_W'($urandom_range(thr, 255));
				else if (thr == 0)
					pv = '0;
				else
					pv = ($urandom_range(0, 99) < 15) ? PIX_W'(thr - 1) :
						PIX_W'($urandom_range(0, thr - 1));
			end
			send_pixel(rt, pv, last);
		end
	endtask

	initial begin
		bit [9:0] directed [16];
		int phase, phase_start, rand_beats, len;
		pix_ch.valid      <= 1'b0;
		pix_ch.req_type   <= 1'b0;
		pix_ch.pixel      <= '0;
		pix_ch.last_pixel <= 1'b0;
		cfg_ch.valid      <= 1'b0;
		cfg_ch.index      <= CFG_BASE_SPEED;
		cfg_ch.data       <= '0;
		arst_n            <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: uncalibrated threshold, line lost, calibration, a line closed
		// by a calibration pixel, then a mixed line and a second lost line
		directed = '{
			{1'b1, 8'd127, 1'b0}, {1'b1, 8'd126, 1'b0}, {1'b1, 8'd255, 1'b0},
			{1'b1, 8'd0, 1'b1},
			{1'b1, 8'd0, 1'b1},
			{1'b0, 8'd60, 1'b0}, {1'b0, 8'd180, 1'b1},
			{1'b1, 8'd255, 1'b0}, {1'b1, 8'd255, 1'b0}, {1'b0, 8'd128, 1'b1},
			{1'b0, 8'd100, 1'b0}, {1'b1, 8'd200, 1'b0}, {1'b1, 8'd120, 1'b0},
			{1'b1, 8'd119, 1'b0}, {1'b1, 8'd121, 1'b1},
			{1'b1, 8'd0, 1'b1}
		};
		foreach (directed[i])
			send_pixel(directed[i][9], directed[i][8:1], directed[i][0]);
		wait_idle();

		// Random phases, each under its own register setting
		phase = 1;
		rand_beats = 0;
		while (rand_beats < RANDOM_BEATS) begin
			case (phase)
				1: write_regs(255, 1, 65535, 15);
				2: write_regs(0, 65535, 0, 0);
				3: write_regs(128, 0, 256, 15);
				default: write_regs($urandom_range(0, 255),
					($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 1500),
					($urandom_range(0, 99) < 70) ? $urandom_range(0, 512) : $urandom_range(0, 65535),
					$urandom_range(0, 15));
			endcase

			if (rand_beats < RANDOM_BEATS / 3) begin
				send_idle_pct = 26;
				recv_idle_pct = 60;
			end else if (rand_beats < 2 * RANDOM_BEATS / 3) begin
				send_idle_pct = 60;
				recv_idle_pct = 26;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end

			phase_start = total_beats;
			if (phase == 1) begin
				// a line past the nominal width, column held at the last position
				send_line(LINE_WIDTH + 10, 1'b0);
			end
			if (phase == 2) begin
				// hold the result side off so the input backs up
				hold_req = 1;
				for (int i = 0; i < 8; i++)
					send_line($urandom_range(2, 4), 1'b0);
			end

			while (total_beats - phase_start < PHASE_BEATS) begin
				len = $urandom_range(0, 99);
				if (len < 12)
					send_line($urandom_range(1, 4), 1'b1);
				else if (len < 85)
					send_line($urandom_range(1, 24), 1'b0);
				else if (len < 97)
					send_line($urandom_range(25, 100), 1'b0);
				else
					send_line($urandom_range(200, LINE_WIDTH + 10), 1'b0);
			end
			rand_beats += total_beats - phase_start;
			wait_idle();
			phase++;
		end

		$display("Ran %0d pixel beats in %0d lines under %0d register settings",
			total_beats, total_lines, settings_used);
		$display("Checked %0d steering beats (%0d with the line lost), %0d mismatches",
			sb.results_checked, sb.lost_lines, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> filelist.f
src/lfpd_pkg.sv
src/lfpd_pix_if.sv
src/lfpd_res_if.sv
src/lfpd_cfg_if.sv
src/lfpd_ctrl.sv
src/lfpd_datapath.sv
src/line_follow_pd_steering.sv
sim/line_follow_pd_steering_tb.sv
